[src/unit_cross_product_top_defines.svh]
// assertion macros for the unit cross product block
// used by unit_cross_product_top.sv, no other dependencies
`ifndef UNIT_CROSS_PRODUCT_TOP_DEFINES_SVH
`define UNIT_CROSS_PRODUCT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define UCP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("unit cross product assertion failed");

// condition never holds
`define UCP_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("unit cross product assertion failed");

`else

`define UCP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define UCP_ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

[src/ucp_pkg.sv]
// shared types and constants of the unit cross product block
// no dependencies
`timescale 1ns / 1ps

package ucp_pkg;

    localparam int COMP_W      = 32;  // q15.16 input and q2.30 result components
    localparam int MAG_W       = 32;  // component magnitude
    localparam int SQ_W        = 64;  // squares and their sums
    localparam int ROOT_W      = 32;
    localparam int REM_W       = 33;
    localparam int FRAC_SH     = 30;
    localparam int QUO_W       = 31;
    localparam int NUM_W       = MAG_W + FRAC_SH;
    localparam int LEN_W       = 31;
    localparam int NORM_STAGES = 5;
    localparam int SQRT_STAGES = SQ_W / 2;
    localparam int DIV_STAGES  = QUO_W;
    localparam int BACK_LAT    = 2 * SQRT_STAGES + DIV_STAGES + 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [LEN_W-1:0] ONE_Q30 = LEN_W'(1) << FRAC_SH;

    typedef enum logic [1:0] {
        STATUS_VALID    = 2'd0,
        STATUS_PARALLEL = 2'd1,
        STATUS_INDET    = 2'd2
    } status_t;

    typedef logic [2:0][MAG_W-1:0] vec_mag_t;

    // one normalized direction pair, as handed from front to back
    typedef struct packed {
        logic     indet;
        logic [2:0] sgn_a;
        logic [2:0] sgn_b;
        vec_mag_t mag_a;
        vec_mag_t mag_b;
    } item_t;

endpackage

[src/ucp_front.sv]
// front end: takes items, flags indeterminate ones, normalizes magnitudes
// depends on ucp_pkg
`timescale 1ns / 1ps

module ucp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [ucp_pkg::COMP_W-1:0] s_a_x,
    input  logic signed [ucp_pkg::COMP_W-1:0] s_a_y,
    input  logic signed [ucp_pkg::COMP_W-1:0] s_a_z,
    input  logic signed [ucp_pkg::COMP_W-1:0] s_b_x,
    input  logic signed [ucp_pkg::COMP_W-1:0] s_b_y,
    input  logic signed [ucp_pkg::COMP_W-1:0] s_b_z,
    input  logic                          s_a_present,
    input  logic                          s_b_present,
    input  logic                          s_a_three_dim,
    input  logic                          s_b_three_dim,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ucp_pkg::item_t                out_item
);

    localparam int NS = ucp_pkg::NORM_STAGES;
    localparam int MW = ucp_pkg::MAG_W;

    logic [NS:0]    vld_reg;
    ucp_pkg::item_t item_reg [NS+1];
    logic [MW-1:0]  ora_reg  [NS+1];
    logic [MW-1:0]  orb_reg  [NS+1];

    logic [2:0][ucp_pkg::COMP_W-1:0] ca, cb;
    ucp_pkg::item_t item0_next;
    logic [MW-1:0]  ora0_next, orb0_next;
    logic           adv;

    assign adv       = !vld_reg[NS] || out_ready;
    assign s_ready   = adv;
    assign out_valid = vld_reg[NS];
    assign out_item  = item_reg[NS];

    // magnitudes, signs, or of magnitudes for the shift search
    always_comb begin
        ca = {s_a_z, s_a_y, s_a_x};
        cb = {s_b_z, s_b_y, s_b_x};
        item0_next = '0;
        ora0_next  = '0;
        orb0_next  = '0;
        for (int i = 0; i < 3; i++) begin
            item0_next.sgn_a[i] = ca[i][MW-1];
            item0_next.sgn_b[i] = cb[i][MW-1];
            item0_next.mag_a[i] = ca[i][MW-1] ? (~ca[i] + MW'(1)) : ca[i];
            item0_next.mag_b[i] = cb[i][MW-1] ? (~cb[i] + MW'(1)) : cb[i];
            ora0_next = ora0_next | item0_next.mag_a[i];
            orb0_next = orb0_next | item0_next.mag_b[i];
        end
        item0_next.indet = !(s_a_present && s_b_present && s_a_three_dim && s_b_three_dim)
                           || (ora0_next == '0) || (orb0_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg[0] <= item0_next;
            ora_reg[0]  <= ora0_next;
            orb_reg[0]  <= orb0_next;
        end
    end

    // binary shift search, widest step first, until bit 30 or 31 is set
    for (genvar k = 1; k <= NS; k++) begin : g_norm
        localparam int SH = 1 << (NS - k);
        logic           sh_a, sh_b;
        ucp_pkg::item_t item_next;
        logic [MW-1:0]  ora_next, orb_next;

        always_comb begin
            sh_a      = (ora_reg[k-1] >> (MW - 1 - SH)) == '0;
            sh_b      = (orb_reg[k-1] >> (MW - 1 - SH)) == '0;
            item_next = item_reg[k-1];
            for (int i = 0; i < 3; i++) begin
                if (sh_a) begin
                    item_next.mag_a[i] = item_reg[k-1].mag_a[i] << SH;
                end
                if (sh_b) begin
                    item_next.mag_b[i] = item_reg[k-1].mag_b[i] << SH;
                end
            end
            ora_next = sh_a ? (ora_reg[k-1] << SH) : ora_reg[k-1];
            orb_next = sh_b ? (orb_reg[k-1] << SH) : orb_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                item_reg[k] <= item_next;
                ora_reg[k]  <= ora_next;
                orb_reg[k]  <= orb_next;
            end
        end
    end

endmodule

[src/ucp_fifo.sv]
// small queue of normalized items between front and back
// depends on ucp_pkg
`timescale 1ns / 1ps

module ucp_fifo #(
    parameter int DEPTH = ucp_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  ucp_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ucp_pkg::item_t pop_item
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ucp_pkg::item_t   mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push, pop;

    assign push_ready = cnt_reg != CNT_W'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[src/ucp_isqrt.sv]
// pipelined integer square root with remainder, one result bit per stage
// depends on ucp_pkg
`timescale 1ns / 1ps

module ucp_isqrt #(
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic [LANES-1:0][ucp_pkg::SQ_W-1:0]     val_i,
    input  logic [SIDE_W-1:0]                       side_i,
    output logic [LANES-1:0][ucp_pkg::ROOT_W-1:0]   root_o,
    output logic [LANES-1:0][ucp_pkg::REM_W-1:0]    rem_o,
    output logic [SIDE_W-1:0]                       side_o
);

    localparam int NS = ucp_pkg::SQRT_STAGES;
    localparam int W  = ucp_pkg::SQ_W;

    logic [W-1:0]      r_reg    [NS][LANES];
    logic [W-1:0]      v_reg    [NS][LANES];
    logic [SIDE_W-1:0] side_reg [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
        logic [W-1:0]      r_in [LANES];
        logic [W-1:0]      v_in [LANES];
        logic [W-1:0]      r_next [LANES];
        logic [W-1:0]      v_next [LANES];
        logic [W-1:0]      trial [LANES];
        logic [SIDE_W-1:0] side_in;

        if (k == 0) begin : g_head
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    r_in[l] = '0;
                    v_in[l] = val_i[l];
                end
                side_in = side_i;
            end
        end else begin : g_body
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    r_in[l] = r_reg[k-1][l];
                    v_in[l] = v_reg[k-1][l];
                end
                side_in = side_reg[k-1];
            end
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = r_in[l] + BIT;
                if (v_in[l] >= trial[l]) begin
                    v_next[l] = v_in[l] - trial[l];
                    r_next[l] = (r_in[l] >> 1) + BIT;
                end else begin
                    v_next[l] = v_in[l];
                    r_next[l] = r_in[l] >> 1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < LANES; l++) begin
                    r_reg[k][l] <= r_next[l];
                    v_reg[k][l] <= v_next[l];
                end
                side_reg[k] <= side_in;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            root_o[l] = r_reg[NS-1][l][ucp_pkg::ROOT_W-1:0];
            rem_o[l]  = v_reg[NS-1][l][ucp_pkg::REM_W-1:0];
        end
    end
    assign side_o = side_reg[NS-1];

endmodule

[src/ucp_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on ucp_pkg
`timescale 1ns / 1ps

module ucp_div #(
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic [LANES-1:0][ucp_pkg::NUM_W-1:0]    num_i,
    input  logic [LANES-1:0][ucp_pkg::ROOT_W-1:0]   den_i,
    input  logic [SIDE_W-1:0]                       side_i,
    output logic [LANES-1:0][ucp_pkg::QUO_W-1:0]    quo_o,
    output logic [SIDE_W-1:0]                       side_o
);

    localparam int NS = ucp_pkg::DIV_STAGES;
    localparam int QW = ucp_pkg::QUO_W;
    localparam int DW = ucp_pkg::ROOT_W;

    logic [DW-1:0]     rem_reg  [NS][LANES];
    logic [QW-1:0]     low_reg  [NS][LANES];
    logic [DW-1:0]     den_reg  [NS][LANES];
    logic [QW-1:0]     quo_reg  [NS][LANES];
    logic [SIDE_W-1:0] side_reg [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [DW-1:0]     rem_in  [LANES];
        logic [QW-1:0]     low_in  [LANES];
        logic [DW-1:0]     den_in  [LANES];
        logic [QW-1:0]     quo_in  [LANES];
        logic [DW:0]       shifted [LANES];
        logic [DW-1:0]     rem_next [LANES];
        logic [QW-1:0]     quo_next [LANES];
        logic [SIDE_W-1:0] side_in;

        if (k == 0) begin : g_head
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = DW'(num_i[l][ucp_pkg::NUM_W-1:QW]);
                    low_in[l] = num_i[l][QW-1:0];
                    den_in[l] = den_i[l];
                    quo_in[l] = '0;
                end
                side_in = side_i;
            end
        end else begin : g_body
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = rem_reg[k-1][l];
                    low_in[l] = low_reg[k-1][l];
                    den_in[l] = den_reg[k-1][l];
                    quo_in[l] = quo_reg[k-1][l];
                end
                side_in = side_reg[k-1];
            end
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                shifted[l]  = {rem_in[l], low_in[l][B]};
                quo_next[l] = quo_in[l];
                if (shifted[l] >= {1'b0, den_in[l]}) begin
                    rem_next[l]    = DW'(shifted[l] - {1'b0, den_in[l]});
                    quo_next[l][B] = 1'b1;
                end else begin
                    rem_next[l] = shifted[l][DW-1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k][l] <= rem_next[l];
                    low_reg[k][l] <= low_in[l];
                    den_reg[k][l] <= den_in[l];
                    quo_reg[k][l] <= quo_next[l];
                end
                side_reg[k] <= side_in;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            quo_o[l] = quo_reg[NS-1][l];
        end
    end
    assign side_o = side_reg[NS-1];

endmodule

[src/ucp_back.sv]
// back end: vector lengths, unit components, cross product, its length
// depends on ucp_pkg, ucp_isqrt, ucp_div
`timescale 1ns / 1ps

module ucp_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ucp_pkg::item_t                  in_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [ucp_pkg::COMP_W-1:0] m_r_x,
    output logic signed [ucp_pkg::COMP_W-1:0] m_r_y,
    output logic signed [ucp_pkg::COMP_W-1:0] m_r_z,
    output logic [ucp_pkg::LEN_W-1:0]       m_length,
    output logic [1:0]                      m_status
);

    localparam int LAT = ucp_pkg::BACK_LAT;
    localparam int CW  = ucp_pkg::COMP_W;
    localparam int SW  = ucp_pkg::SQ_W;
    localparam int RW  = ucp_pkg::ROOT_W;
    localparam int LW  = ucp_pkg::LEN_W;

    typedef struct packed {
        logic       indet;
        logic [2:0] sgn_a;
        logic [2:0] sgn_b;
    } sgn_t;

    typedef struct packed {
        logic              indet;
        logic [2:0][CW-1:0] ua;
    } mid_t;

    typedef struct packed {
        logic              indet;
        logic              rzero;
        logic [2:0][CW-1:0] ua;
        logic [2:0][CW-1:0] r;
    } tail_t;

    // q4.60 to q2.30, half away from zero, saturated
    function automatic logic [CW-1:0] round_q30(input logic [SW-1:0] p);
        logic [SW-1:0] mag;
        logic [SW-1:0] q;
        logic [CW-1:0] res;
        mag = p[SW-1] ? (~p + SW'(1)) : p;
        q   = (mag + (SW'(1) << (ucp_pkg::FRAC_SH - 1))) >> ucp_pkg::FRAC_SH;
        if (p[SW-1]) begin
            if (q > (SW'(1) << (CW - 1))) begin
                q = SW'(1) << (CW - 1);
            end
            res = CW'(~q + SW'(1));
        end else if (q > ((SW'(1) << (CW - 1)) - SW'(1))) begin
            res = {1'b0, {(CW - 1){1'b1}}};
        end else begin
            res = q[CW-1:0];
        end
        return res;
    endfunction

    logic [LAT-1:0]        vld_reg;
    logic                  adv;

    logic [1:0][2:0][SW-1:0] sq_reg;
    ucp_pkg::item_t        p1_item_reg;
    logic [1:0][SW-1:0]    sum_reg;
    ucp_pkg::item_t        p2_item_reg;

    logic [1:0][RW-1:0]    root_ab;
    logic [1:0][ucp_pkg::REM_W-1:0] rem_ab;
    ucp_pkg::item_t        sq_item;

    logic [5:0][ucp_pkg::NUM_W-1:0] num_reg;
    logic [5:0][RW-1:0]    den_reg;
    sgn_t                  p3_sgn_reg;

    logic [5:0][ucp_pkg::QUO_W-1:0] quo;
    sgn_t                  div_sgn;

    logic [2:0][CW-1:0]    ua_reg, ub_reg;
    logic                  p4_indet_reg;
    logic [5:0][SW-1:0]    prod_reg;
    mid_t                  p5_mid_reg;
    logic [2:0][SW-1:0]    diff_reg;
    mid_t                  p6_mid_reg;
    logic [2:0][CW-1:0]    r_reg;
    mid_t                  p7_mid_reg;
    logic [2:0][SW-1:0]    rsq_reg;
    tail_t                 p8_tail_reg;
    logic [0:0][SW-1:0]    rsum_reg;
    tail_t                 p9_tail_reg;

    logic [0:0][RW-1:0]    root_r;
    logic [0:0][ucp_pkg::REM_W-1:0] rem_r;
    tail_t                 fin_tail;

    logic [RW:0]           len_round;
    logic [2:0][CW-1:0]    out_r_next;
    logic [LW-1:0]         out_len_next;
    ucp_pkg::status_t      out_status_next;

    logic [2:0][CW-1:0]    out_r_reg;
    logic [LW-1:0]         out_len_reg;
    ucp_pkg::status_t      out_status_reg;

    assign adv      = !vld_reg[LAT-1] || m_ready;
    assign in_ready = adv;
    assign m_valid  = vld_reg[LAT-1];
    assign m_r_x    = out_r_reg[0];
    assign m_r_y    = out_r_reg[1];
    assign m_r_z    = out_r_reg[2];
    assign m_length = out_len_reg;
    assign m_status = out_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    ucp_isqrt #(
        .LANES  (2),
        .SIDE_W ($bits(ucp_pkg::item_t))
    ) u_len_ab (
        .aclk   (aclk),
        .en     (adv),
        .val_i  (sum_reg),
        .side_i (p2_item_reg),
        .root_o (root_ab),
        .rem_o  (rem_ab),
        .side_o (sq_item)
    );

    ucp_div #(
        .LANES  (6),
        .SIDE_W ($bits(sgn_t))
    ) u_div (
        .aclk   (aclk),
        .en     (adv),
        .num_i  (num_reg),
        .den_i  (den_reg),
        .side_i (p3_sgn_reg),
        .quo_o  (quo),
        .side_o (div_sgn)
    );

    ucp_isqrt #(
        .LANES  (1),
        .SIDE_W ($bits(tail_t))
    ) u_len_r (
        .aclk   (aclk),
        .en     (adv),
        .val_i  (rsum_reg),
        .side_i (p9_tail_reg),
        .root_o (root_r),
        .rem_o  (rem_r),
        .side_o (fin_tail)
    );

    // length rounded to nearest, saturated at one, and result selection
    always_comb begin
        len_round = {1'b0, root_r[0]};
        if (rem_r[0] > {1'b0, root_r[0]}) begin
            len_round = {1'b0, root_r[0]} + (RW + 1)'(1);
        end
        if (fin_tail.indet) begin
            out_r_next      = '0;
            out_len_next    = '0;
            out_status_next = ucp_pkg::STATUS_INDET;
        end else if (fin_tail.rzero) begin
            out_r_next      = fin_tail.ua;
            out_len_next    = '0;
            out_status_next = ucp_pkg::STATUS_PARALLEL;
        end else begin
            out_r_next      = fin_tail.r;
            out_status_next = ucp_pkg::STATUS_VALID;
            if (len_round > (RW + 1)'(ucp_pkg::ONE_Q30)) begin
                out_len_next = ucp_pkg::ONE_Q30;
            end else begin
                out_len_next = len_round[LW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // squares of the normalized magnitudes
            for (int i = 0; i < 3; i++) begin
                sq_reg[0][i] <= SW'(in_item.mag_a[i]) * SW'(in_item.mag_a[i]);
                sq_reg[1][i] <= SW'(in_item.mag_b[i]) * SW'(in_item.mag_b[i]);
            end
            p1_item_reg <= in_item;

            for (int v = 0; v < 2; v++) begin
                sum_reg[v] <= sq_reg[v][0] + sq_reg[v][1] + sq_reg[v][2];
            end
            p2_item_reg <= p1_item_reg;

            // dividend m * 2^30 + len / 2
            for (int i = 0; i < 3; i++) begin
                num_reg[i]     <= {sq_item.mag_a[i], {ucp_pkg::FRAC_SH{1'b0}}}
                                  + ucp_pkg::NUM_W'(root_ab[0] >> 1);
                num_reg[3 + i] <= {sq_item.mag_b[i], {ucp_pkg::FRAC_SH{1'b0}}}
                                  + ucp_pkg::NUM_W'(root_ab[1] >> 1);
                den_reg[i]     <= root_ab[0];
                den_reg[3 + i] <= root_ab[1];
            end
            p3_sgn_reg.indet <= sq_item.indet;
            p3_sgn_reg.sgn_a <= sq_item.sgn_a;
            p3_sgn_reg.sgn_b <= sq_item.sgn_b;

            for (int i = 0; i < 3; i++) begin
                ua_reg[i] <= div_sgn.sgn_a[i] ? (~CW'(quo[i]) + CW'(1)) : CW'(quo[i]);
                ub_reg[i] <= div_sgn.sgn_b[i] ? (~CW'(quo[3 + i]) + CW'(1))
                                              : CW'(quo[3 + i]);
            end
            p4_indet_reg <= div_sgn.indet;

            prod_reg[0] <= SW'($signed(ua_reg[1]) * $signed(ub_reg[2]));
            prod_reg[1] <= SW'($signed(ua_reg[2]) * $signed(ub_reg[1]));
            prod_reg[2] <= SW'($signed(ua_reg[2]) * $signed(ub_reg[0]));
            prod_reg[3] <= SW'($signed(ua_reg[0]) * $signed(ub_reg[2]));
            prod_reg[4] <= SW'($signed(ua_reg[0]) * $signed(ub_reg[1]));
            prod_reg[5] <= SW'($signed(ua_reg[1]) * $signed(ub_reg[0]));
            p5_mid_reg.indet <= p4_indet_reg;
            p5_mid_reg.ua    <= ua_reg;

            for (int i = 0; i < 3; i++) begin
                diff_reg[i] <= prod_reg[2 * i] - prod_reg[2 * i + 1];
            end
            p6_mid_reg <= p5_mid_reg;

            for (int i = 0; i < 3; i++) begin
                r_reg[i] <= round_q30(diff_reg[i]);
            end
            p7_mid_reg <= p6_mid_reg;

            for (int i = 0; i < 3; i++) begin
                rsq_reg[i] <= SW'($signed(r_reg[i]) * $signed(r_reg[i]));
            end
            p8_tail_reg.indet <= p7_mid_reg.indet;
            p8_tail_reg.rzero <= (r_reg == '0);
            p8_tail_reg.ua    <= p7_mid_reg.ua;
            p8_tail_reg.r     <= r_reg;

            rsum_reg[0] <= rsq_reg[0] + rsq_reg[1] + rsq_reg[2];
            p9_tail_reg <= p8_tail_reg;

            out_r_reg      <= out_r_next;
            out_len_reg    <= out_len_next;
            out_status_reg <= out_status_next;
        end
    end

endmodule

[src/unit_cross_product_top.sv]
// top level of the unit cross product block: front, queue and back
// depends on ucp_pkg, ucp_front, ucp_fifo, ucp_back and the defines header
//
//   channel | ports        | moves
//   --------+--------------+---------------------------------------------
//   input   | s_valid/ready| two q15.16 directions with present, 3-d flags
//   result  | m_valid/ready| q2.30 unit cross product, length, status
//
// one item per cycle sustained while results are taken; the pipelines never recirculate
// results pass through the front, the queue and the back, whose stages are
// two 32-stage square roots, a 31-stage divider and 10 arithmetic stages
// synchronous active-low reset clears valid bits, queue pointers and queue count only
// a stalled result holds the back pipeline; the queue absorbs the front
// pipeline so s_ready drops only once the queue is full
`timescale 1ns / 1ps
`include "unit_cross_product_top_defines.svh"

module unit_cross_product_top #(
    parameter int QUEUE_DEPTH = ucp_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [ucp_pkg::COMP_W-1:0] s_a_x,
    input  logic signed [ucp_pkg::COMP_W-1:0] s_a_y,
    input  logic signed [ucp_pkg::COMP_W-1:0] s_a_z,
    input  logic signed [ucp_pkg::COMP_W-1:0] s_b_x,
    input  logic signed [ucp_pkg::COMP_W-1:0] s_b_y,
    input  logic signed [ucp_pkg::COMP_W-1:0] s_b_z,
    input  logic                              s_a_present,
    input  logic                              s_b_present,
    input  logic                              s_a_three_dim,
    input  logic                              s_b_three_dim,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ucp_pkg::COMP_W-1:0] m_r_x,
    output logic signed [ucp_pkg::COMP_W-1:0] m_r_y,
    output logic signed [ucp_pkg::COMP_W-1:0] m_r_z,
    output logic [ucp_pkg::LEN_W-1:0]         m_length,
    output logic [1:0]                        m_status
);

    // front to queue
    logic           front_valid, front_ready;
    ucp_pkg::item_t front_item;
    // queue to back
    logic           queue_valid, queue_ready;
    ucp_pkg::item_t queue_item;

    // classify and normalize
    ucp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_a_x         (s_a_x),
        .s_a_y         (s_a_y),
        .s_a_z         (s_a_z),
        .s_b_x         (s_b_x),
        .s_b_y         (s_b_y),
        .s_b_z         (s_b_z),
        .s_a_present   (s_a_present),
        .s_b_present   (s_b_present),
        .s_a_three_dim (s_a_three_dim),
        .s_b_three_dim (s_b_three_dim),
        .out_valid     (front_valid),
        .out_ready     (front_ready),
        .out_item      (front_item)
    );

    // decouples the front from result stalls
    ucp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    // lengths, division, cross product and output register
    ucp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (queue_valid),
        .in_ready (queue_ready),
        .in_item  (queue_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_r_x    (m_r_x),
        .m_r_y    (m_r_y),
        .m_r_z    (m_r_z),
        .m_length (m_length),
        .m_status (m_status)
    );

    // indeterminate results carry no direction and no length
    `UCP_ASSERT_IMP(a_indet_zero, aclk, aresetn, m_valid && m_status == ucp_pkg::STATUS_INDET, m_r_x == '0 && m_r_y == '0 && m_r_z == '0 && m_length == '0)
    // parallel inputs report zero length
    `UCP_ASSERT_IMP(a_par_len, aclk, aresetn, m_valid && m_status == ucp_pkg::STATUS_PARALLEL, m_length == '0)
    // a valid cross product has a nonzero length of at most one
    `UCP_ASSERT_IMP(a_valid_len, aclk, aresetn, m_valid && m_status == ucp_pkg::STATUS_VALID, m_length != '0 && m_length <= ucp_pkg::ONE_Q30)
    // the queue is never full and empty at once
    `UCP_ASSERT_NEVER(a_queue_cnt, aclk, aresetn, !front_ready && !queue_valid)

endmodule

[tb/sv/tb.sv]
// testbench for the normalized 3-d cross product block, both handshakes randomly idled
// predicts every result in-bench and checks it in order; depends on ucp_pkg and the top level
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES   = 200;   // covers the whole pipeline
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off

    // one predicted result item
    typedef struct {
        logic signed [ucp_pkg::COMP_W-1:0] x, y, z;
        logic [ucp_pkg::LEN_W-1:0]         len;
        ucp_pkg::status_t                  st;
    } cross_res_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic signed [ucp_pkg::COMP_W-1:0] s_a_x = '0, s_a_y = '0, s_a_z = '0;
    logic signed [ucp_pkg::COMP_W-1:0] s_b_x = '0, s_b_y = '0, s_b_z = '0;
    logic                              s_a_present = 1'b0, s_b_present = 1'b0;
    logic                              s_a_three_dim = 1'b0, s_b_three_dim = 1'b0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic signed [ucp_pkg::COMP_W-1:0] m_r_x, m_r_y, m_r_z;
    logic [ucp_pkg::LEN_W-1:0]         m_length;
    logic [1:0]                        m_status;

    cross_res_t pending_results[$];
    int         failures = 0;
    bit         send_idle_en = 1'b1;
    bit         recv_idle_en = 1'b1;
    bit         hold_req = 1'b0;
    int         stuck_cycles = 0;

    unit_cross_product_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_x(s_a_x), .s_a_y(s_a_y), .s_a_z(s_a_z),
        .s_b_x(s_b_x), .s_b_y(s_b_y), .s_b_z(s_b_z),
        .s_a_present(s_a_present), .s_b_present(s_b_present),
        .s_a_three_dim(s_a_three_dim), .s_b_three_dim(s_b_three_dim),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_r_x(m_r_x), .m_r_y(m_r_y), .m_r_z(m_r_z),
        .m_length(m_length), .m_status(m_status)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // bitwise integer square root, floor
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale a q15.16 direction to unit length in q2.30; 0 if it is all zero
    function automatic bit unit_dir(input longint c[3], output longint u[3]);
        logic [63:0] m[3];
        logic [63:0] mx, sum, root, q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (c[i] < 0) ? -c[i] : c[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return 1'b0;
        // normalize so the largest magnitude reaches 2^30
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
        root = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + (root >> 1)) / root;
            u[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    // q4.60 down to q2.30, half away from zero, saturated to 32 bits
    function automatic longint round_to_q30(input longint p);
        logic [63:0] mag, q;
        mag = (p < 0) ? -p : p;
        q = (mag + (64'd1 << 29)) >> 30;
        if (p < 0) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return -longint'(q);
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return longint'(q);
    endfunction

    function automatic cross_res_t predict_cross(
        input logic signed [31:0] ax, ay, az, bx, by, bz,
        input logic ap, bp, a3, b3);
        cross_res_t  res;
        longint      a[3], b[3], ua[3], ub[3], r[3];
        logic [63:0] sum, root;
        bit          ok_a, ok_b;
        a = '{ax, ay, az};
        b = '{bx, by, bz};
        r = '{0, 0, 0};
        root = 0;
        sum = 0;
        res.st = ucp_pkg::STATUS_VALID;
        ok_a = unit_dir(a, ua);
        ok_b = unit_dir(b, ub);
        if (!ap || !bp || !a3 || !b3 || !ok_a || !ok_b) begin
            res.st = ucp_pkg::STATUS_INDET;
        end else begin
            r[0] = round_to_q30(ua[1] * ub[2] - ua[2] * ub[1]);
            r[1] = round_to_q30(ua[2] * ub[0] - ua[0] * ub[2]);
            r[2] = round_to_q30(ua[0] * ub[1] - ua[1] * ub[0]);
            if (r[0] == 0 && r[1] == 0 && r[2] == 0) begin
                // parallel: hand back the unit first direction, no length
                res.st = ucp_pkg::STATUS_PARALLEL;
                r = ua;
            end else begin
                for (int i = 0; i < 3; i++) sum = sum + r[i] * r[i];
                root = int_sqrt(sum);
                if (sum - root * root > root) root = root + 1;
                if (root > (64'd1 << 30)) root = 64'd1 << 30;
            end
        end
        res.x = r[0][31:0];
        res.y = r[1][31:0];
        res.z = r[2][31:0];
        res.len = root[30:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // offer one item, hold it until taken, then maybe go quiet a while
    task automatic send_pair(input logic signed [31:0] ax, ay, az, bx, by, bz,
                             input logic ap, bp, a3, b3);
        s_valid <= 1'b1;
        s_a_x <= ax; s_a_y <= ay; s_a_z <= az;
        s_b_x <= bx; s_b_y <= by; s_b_z <= bz;
        s_a_present <= ap; s_b_present <= bp;
        s_a_three_dim <= a3; s_b_three_dim <= b3;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_cross(ax, ay, az, bx, by, bz, ap, bp, a3, b3));
        // each following cycle idles with the same odds, so about 31 in 100 are idle
        if (send_idle_en && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 31);
        end
    endtask

    task automatic send_valid3(input logic signed [31:0] ax, ay, az, bx, by, bz);
        send_pair(ax, ay, az, bx, by, bz, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    // random component, spread over small, mid and full-range magnitudes
    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2 * 65536)) - 65536;
            2: return 32'sd1 <<< $urandom_range(0, 31);
            3: return 0;
            4: return $signed($urandom_range(0, 200)) - 100;
            default: return $urandom >>> $urandom_range(0, 31);
        endcase
    endfunction

    // one random item: mostly well-formed, some parallel pairs, some flagged off
    task automatic send_random();
        logic signed [31:0] a[3], b[3];
        int k, kind;
        for (int i = 0; i < 3; i++) begin
            a[i] = rand_comp();
            b[i] = rand_comp();
        end
        kind = $urandom_range(99);
        if (kind < 15) begin
            // parallel or anti-parallel: b a small multiple of a
            k = $signed($urandom_range(0, 14)) - 7;
            if (k == 0) k = 1;
            for (int i = 0; i < 3; i++) begin
                a[i] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                b[i] = a[i] * k;
            end
        end else if (kind < 20) begin
            // nearly parallel, each component off by at most one lsb
            for (int i = 0; i < 3; i++) b[i] = a[i] + $signed($urandom_range(0, 2)) - 1;
        end
        if (kind >= 90)
            send_pair(a[0], a[1], a[2], b[0], b[1], b[2],
                      1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
        else
            send_valid3(a[0], a[1], a[2], b[0], b[1], b[2]);
    endtask

    // ---------------------------------------------------------------
    // receiver side: random ready, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_idle_en) begin
                m_ready <= ($urandom_range(99) >= 31);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker, in order against the oldest prediction
    always @(posedge aclk) begin
        cross_res_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result item with nothing expected", $time);
                failures++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_r_x !== exp_res.x) begin
                    $display("%0t: r_x expected %h got %h", $time, exp_res.x, m_r_x);
                    failures++;
                end
                if (m_r_y !== exp_res.y) begin
                    $display("%0t: r_y expected %h got %h", $time, exp_res.y, m_r_y);
                    failures++;
                end
                if (m_r_z !== exp_res.z) begin
                    $display("%0t: r_z expected %h got %h", $time, exp_res.z, m_r_z);
                    failures++;
                end
                if (m_length !== exp_res.len) begin
                    $display("%0t: length expected %h got %h", $time, exp_res.len, m_length);
                    failures++;
                end
                if (m_status !== exp_res.st) begin
                    $display("%0t: status expected %0d got %0d", $time, exp_res.st, m_status);
                    failures++;
                end
            end
        end
    end

    // watchdog: too long without any item moving ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (aresetn && (s_valid || pending_results.size() != 0)) begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // extremes, axes, every status and each special case
    task automatic test_directed();
        logic signed [31:0] mx, mn, one;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        one = 32'sd65536;
        send_valid3(one, 0, 0, 0, one, 0);            // x cross y gives z
        send_valid3(0, one, 0, one, 0, 0);            // y cross x gives -z
        send_valid3(mx, mx, mx, mn, mn, mn);          // anti-parallel extremes
        send_valid3(mn, 0, 0, 0, mn, 0);
        send_valid3(mx, mn, 1, -1, mx, mn);
        send_valid3(1, 0, 0, 0, 0, 1);                // tiniest magnitudes
        send_valid3(one, one, 0, one, one, 0);        // identical
        send_valid3(3, 5, 7, -6, -10, -14);           // scaled opposite
        send_valid3(0, 0, 0, one, 0, 0);              // zero-length first
        send_valid3(one, 0, 0, 0, 0, 0);              // zero-length second
        send_pair(one, 0, 0, 0, one, 0, 1'b0, 1'b1, 1'b1, 1'b1);  // first missing
        send_pair(one, 0, 0, 0, one, 0, 1'b1, 1'b0, 1'b1, 1'b1);  // second missing
        send_pair(one, 0, 0, 0, one, 0, 1'b1, 1'b1, 1'b0, 1'b1);  // first 2-d
        send_pair(one, 0, 0, 0, one, 0, 1'b1, 1'b1, 1'b1, 1'b0);  // second 2-d
        send_pair(mn, mx, mn, mx, mn, mx, 1'b0, 1'b0, 1'b0, 1'b0);
        send_valid3(mx, 0, mx, 0, mx, 0);
        send_valid3(-1, -1, -1, 1, -1, 1);
        send_valid3(mn, mn, mn, mn, mn, mn);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_random();
    endtask

    // both sides flat out for a long stretch
    task automatic test_full_rate(input int count);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        repeat (count) send_random();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    // receiver holds off while items keep coming, so the input must stall
    task automatic test_backpressure(input int count);
        send_idle_en = 1'b0;
        hold_req = 1'b1;
        repeat (count) send_random();
        send_idle_en = 1'b1;
    endtask

    // sender goes quiet until every outstanding result is back
    task automatic test_drain_pause();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_mix(700);
        test_full_rate(400);
        test_backpressure(300);
        test_drain_pause();
        test_random_mix(600);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
